/* src/spa_pkg.sv */
// Shared constants for the slab page allocator.
`timescale 1ns / 1ps
package spa_pkg;

  localparam int DEF_MAX_PAGES        = 256;
  localparam int DEF_PAGE_BYTES       = 4096;
  localparam int DEF_META_ENTRY_BYTES = 16;
  localparam int DEF_MIN_ENTRY_BYTES  = 4;

  localparam int SIZE_FIELD_W  = 13;
  localparam int ADDR_W        = 32;
  localparam int STATUS_W      = 3;
  localparam int PAGES_FIELD_W = 9;
  localparam int CFG_IDX_W     = 8;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOREIGN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISALIGN  = 3'd4;

  localparam logic [1:0] KIND_UNUSED = 2'd0;
  localparam logic [1:0] KIND_META   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_PAGES = 8'd1;

  localparam logic MODE_ALLOC = 1'b0;

endpackage

/* src/slab_page_allocator.sv */
// Slab page allocator top level: descriptor and link memories with a sequencer.
`timescale 1ns / 1ps
//
//  channel | direction | handshake         | content
//  --------+-----------+-------------------+------------------------------------------
//  in_     | slave     | tvalid/tready     | mode, req_size, free_address
//  out_    | master    | tvalid/tready     | address, status
//  cfg_    | slave     | valid/ready       | register index, write data (always ready)
//
//  One request at a time. An allocate scans page descriptors from the newest
//  page down, one descriptor memory read per cycle; a hit may then need a pop
//  through the link memory, and a miss tries a fresh slab. A free runs a
//  bit-serial divide of the page offset by the entry size.
//  Reset (rst_n low, synchronous) or a base/page-count config write clears the
//  allocator; no clearing pass: descriptors beyond pages_used are never trusted.
//  The output register holds a result while out_tready is low; the next
//  transaction is accepted meanwhile and waits only at its own result.
module slab_page_allocator #(
  parameter int MAX_PAGES        = spa_pkg::DEF_MAX_PAGES,
  parameter int PAGE_BYTES       = spa_pkg::DEF_PAGE_BYTES,
  parameter int META_ENTRY_BYTES = spa_pkg::DEF_META_ENTRY_BYTES,
  parameter int MIN_ENTRY_BYTES  = spa_pkg::DEF_MIN_ENTRY_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [0] mode, [13:1] req_size, [45:14] free_address, [47:46] zero
  input  logic [47:0]                   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] address, [34:32] status, [39:35] zero
  output logic [39:0]                   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spa_pkg::ADDR_W-1:0]    cfg_data
);
  import spa_pkg::*;

  localparam int PG_W   = $clog2(MAX_PAGES);
  localparam int PU_W   = $clog2(MAX_PAGES + 1);
  localparam int PW     = $clog2(PAGE_BYTES);
  localparam int SZ_W   = PW + 1;
  localparam int LINKS  = PAGE_BYTES / MIN_ENTRY_BYTES;
  localparam int LIW    = $clog2(LINKS);
  localparam int HW     = LIW + 1;
  localparam int META_SLOTS = PAGE_BYTES / META_ENTRY_BYTES - 2;
  localparam int MS_W   = $clog2(META_SLOTS + 1);
  localparam int CNT_W  = $clog2(PW);
  localparam int LA_W   = PG_W + LIW;

  localparam logic [HW-1:0]   HEAD_EMPTY = HW'(LINKS);
  localparam logic [SZ_W+1:0] PAGE_SZ    = (SZ_W+2)'(PAGE_BYTES);

  typedef struct packed {
    logic [1:0]      kind;
    logic [SZ_W-1:0] esize;
    logic [HW-1:0]   head;
    logic [SZ_W-1:0] bump;
  } desc_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_POP  = 9'b000000100,
    S_NEW  = 9'b000001000,
    S_NEWD = 9'b000010000,
    S_FRD  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_FCHK = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  // memories
  desc_t            desc_mem [MAX_PAGES];
  desc_t            desc_q;
  logic [HW-1:0]    link_mem [MAX_PAGES*LINKS];
  logic [HW-1:0]    link_q;

  logic             desc_we;
  logic [PG_W-1:0]  desc_waddr, desc_raddr;
  desc_t            desc_wdata;
  logic             link_we;
  logic [LA_W-1:0]  link_waddr, link_raddr;
  logic [HW-1:0]    link_wdata;

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
    desc_q <= desc_mem[desc_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[link_raddr];
  end

  // registers
  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    base_r, base_nxt;
  logic [PAGES_FIELD_W-1:0] mpages_r, mpages_nxt;
  logic [PU_W-1:0]      used_r, used_nxt;
  logic [MS_W-1:0]      mleft_r, mleft_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0]  out_st_r, out_st_nxt;

  logic [SZ_W-1:0]      size_r, size_nxt;
  logic [PG_W-1:0]      pg_r, pg_nxt;        // page being evaluated / acted on
  logic [PG_W-1:0]      scan_r, scan_nxt;    // next page to read
  logic                 more_r, more_nxt;
  logic [PW-1:0]        off_r, off_nxt;
  logic [STATUS_W-1:0]  st_r, st_nxt;
  logic                 give_r, give_nxt;    // address valid for the result
  desc_t                dsv_r, dsv_nxt;
  logic [PW-1:0]        within_r, within_nxt;
  logic [PW-1:0]        wq_r, wq_nxt;
  logic [SZ_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // request fields
  logic                 in_mode;
  logic [SIZE_FIELD_W-1:0] in_size;
  logic [ADDR_W-1:0]    in_faddr;
  assign in_mode  = in_tdata[0];
  assign in_size  = in_tdata[13:1];
  assign in_faddr = in_tdata[45:14];

  logic [ADDR_W-1:0]    foff;
  logic                 fpage_out;
  logic [31:0]          limit;
  logic [31:0]          need_top;
  logic                 hit, can_bump;
  logic [SZ_W:0]        dtmp;
  logic                 dbit;
  logic [HW+SZ_W-1:0]   prod;

  assign foff      = in_faddr - base_r;
  assign fpage_out = 32'(foff[ADDR_W-1:PW]) >= 32'(used_r);
  assign limit     = (32'(mpages_r) < 32'(MAX_PAGES)) ? 32'(mpages_r) : 32'(MAX_PAGES);
  assign need_top  = 32'(used_r) + ((mleft_r == '0) ? 32'd2 : 32'd1);
  assign can_bump  = ({2'b00, desc_q.bump} + {1'b0, size_r, 1'b0} <= PAGE_SZ)
                     || (desc_q.bump == '0);
  assign hit       = (desc_q.kind == KIND_DATA) && (pg_r != '0) && (desc_q.esize == size_r)
                     && ((desc_q.head != HEAD_EMPTY) || can_bump);
  assign dtmp      = {rem_r, wq_r[PW-1]};
  assign dbit      = dtmp >= {1'b0, dsv_r.esize};
  assign prod      = dsv_r.head * size_r;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_st_r, out_addr_r};

  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    mpages_nxt   = mpages_r;
    used_nxt     = used_r;
    mleft_nxt    = mleft_r;
    out_vld_nxt  = out_vld_r;
    out_addr_nxt = out_addr_r;
    out_st_nxt   = out_st_r;
    size_nxt     = size_r;
    pg_nxt       = pg_r;
    scan_nxt     = scan_r;
    more_nxt     = more_r;
    off_nxt      = off_r;
    st_nxt       = st_r;
    give_nxt     = give_r;
    dsv_nxt      = dsv_r;
    within_nxt   = within_r;
    wq_nxt       = wq_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    desc_we      = 1'b0;
    desc_waddr   = pg_r;
    desc_wdata   = dsv_r;
    desc_raddr   = scan_r;
    link_we      = 1'b0;
    link_waddr   = {pg_r, wq_r[LIW-1:0]};
    link_wdata   = dsv_r.head;
    link_raddr   = {pg_r, desc_q.head[LIW-1:0]};

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt   = ST_OK;
          give_nxt = 1'b0;
          off_nxt  = '0;
          if (in_mode == MODE_ALLOC) begin
            if (32'(in_size) < 32'(MIN_ENTRY_BYTES) || 32'(in_size) > 32'(PAGE_BYTES)) begin
              st_nxt    = ST_BAD_SIZE;
              state_nxt = S_FIN;
            end else begin
              size_nxt   = SZ_W'(in_size);
              desc_raddr = PG_W'(used_r - 1'b1);
              pg_nxt     = PG_W'(used_r - 1'b1);
              scan_nxt   = PG_W'(used_r - 2'd2);
              more_nxt   = used_r > PU_W'(1);
              state_nxt  = S_SCAN;
            end
          end else if (in_faddr == '0) begin
            state_nxt = S_FIN;
          end else if (fpage_out) begin
            st_nxt    = ST_FOREIGN;
            state_nxt = S_FIN;
          end else begin
            desc_raddr = foff[PW+PG_W-1:PW];
            pg_nxt     = foff[PW+PG_W-1:PW];
            within_nxt = foff[PW-1:0];
            wq_nxt     = foff[PW-1:0];
            state_nxt  = S_FRD;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          dsv_nxt = desc_q;
          if (desc_q.head != HEAD_EMPTY) begin
            state_nxt = S_POP;          // link read issued at {pg, head}
          end else begin
            desc_we         = 1'b1;
            desc_wdata      = desc_q;
            desc_wdata.bump = desc_q.bump + size_r;
            off_nxt         = desc_q.bump[PW-1:0];
            give_nxt        = 1'b1;
            state_nxt       = S_FIN;
          end
        end else if (more_r) begin
          pg_nxt   = scan_r;
          scan_nxt = scan_r - 1'b1;
          more_nxt = scan_r != '0;
        end else begin
          state_nxt = S_NEW;
        end
      end

      S_POP: begin
        desc_we         = 1'b1;
        desc_wdata      = dsv_r;
        desc_wdata.head = link_q;
        off_nxt         = prod[PW-1:0];
        give_nxt        = 1'b1;
        state_nxt       = S_FIN;
      end

      S_NEW: begin
        if (need_top > limit) begin
          st_nxt    = ST_NO_MEM;
          state_nxt = S_FIN;
        end else begin
          if (mleft_r == '0) begin
            desc_we         = 1'b1;
            desc_waddr      = PG_W'(used_r);
            desc_wdata.kind = KIND_META;
            used_nxt        = used_r + 1'b1;
            mleft_nxt       = MS_W'(META_SLOTS);
          end
          state_nxt = S_NEWD;
        end
      end

      S_NEWD: begin
        desc_we          = 1'b1;
        desc_waddr       = PG_W'(used_r);
        desc_wdata.kind  = KIND_DATA;
        desc_wdata.esize = size_r;
        desc_wdata.head  = HEAD_EMPTY;
        desc_wdata.bump  = size_r;
        mleft_nxt        = mleft_r - 1'b1;
        used_nxt         = used_r + 1'b1;
        pg_nxt           = PG_W'(used_r);
        off_nxt          = '0;
        give_nxt         = 1'b1;
        state_nxt        = S_FIN;
      end

      S_FRD: begin
        dsv_nxt = desc_q;
        if (desc_q.kind != KIND_DATA || pg_r == '0) begin
          st_nxt    = ST_FOREIGN;
          state_nxt = S_FIN;
        end else begin
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(PW - 1);
          state_nxt = S_DIV;
        end
      end

      // restoring divide: within / entry size, one quotient bit a cycle
      S_DIV: begin
        rem_nxt = dbit ? SZ_W'(dtmp - {1'b0, dsv_r.esize}) : SZ_W'(dtmp);
        wq_nxt  = {wq_r[PW-2:0], dbit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FCHK;
        end
      end

      S_FCHK: begin
        if (rem_r != '0 || !((within_r == '0) ||
            ({2'b00, 1'b0, within_r} + {1'b0, dsv_r.esize, 1'b0} <= PAGE_SZ))) begin
          st_nxt = ST_MISALIGN;
        end else begin
          link_we         = 1'b1;
          desc_we         = 1'b1;
          desc_wdata      = dsv_r;
          desc_wdata.head = HW'(wq_r[LIW-1:0]);
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_st_nxt   = st_r;
          out_addr_nxt = give_r ? base_r + ADDR_W'({pg_r, off_r}) : '0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // config write to MEM_BASE or MEM_PAGES clears the allocator
    if (cfg_valid) begin
      if (cfg_index == REG_MEM_BASE) begin
        base_nxt = cfg_data;
        used_nxt = PU_W'(1);
        mleft_nxt = MS_W'(META_SLOTS);
      end else if (cfg_index == REG_MEM_PAGES) begin
        mpages_nxt = cfg_data[PAGES_FIELD_W-1:0];
        used_nxt = PU_W'(1);
        mleft_nxt = MS_W'(META_SLOTS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      base_r    <= '0;
      mpages_r  <= PAGES_FIELD_W'(256);
      used_r    <= PU_W'(1);
      mleft_r   <= MS_W'(META_SLOTS);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      mpages_r  <= mpages_nxt;
      used_r    <= used_nxt;
      mleft_r   <= mleft_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
    size_r     <= size_nxt;
    pg_r       <= pg_nxt;
    scan_r     <= scan_nxt;
    more_r     <= more_nxt;
    off_r      <= off_nxt;
    st_r       <= st_nxt;
    give_r     <= give_nxt;
    dsv_r      <= dsv_nxt;
    within_r   <= within_nxt;
    wq_r       <= wq_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
  end

endmodule
